>>> rtl/core/nearest_sample_position_fill_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest sample position fill block
// Shared concurrent-assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SAMPLE_POSITION_FILL_ASSERT_SVH
`define NEAREST_SAMPLE_POSITION_FILL_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define NSPF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define NSPF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NSPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/nspf_pkg.sv
// ----------------------------------------------------------------------------
// nspf_pkg
// Types, codes and constants shared by the nearest sample position fill block.
// ----------------------------------------------------------------------------
package nspf_pkg;

  localparam int PENDING_DEPTH_DEF = 63;
  localparam int CFG_AW            = 3;

  localparam logic [31:0] MID_LED  = 32'h8080_8080;
  localparam logic [31:0] MID_POSE = 32'h8080_0000;

  // configuration register indexes (byte address bit 2)
  localparam logic REG_POS_CODE  = 1'b0;
  localparam logic REG_FILL_MODE = 1'b1;

  // filled_from codes
  localparam logic [1:0] FROM_PASS    = 2'd0;
  localparam logic [1:0] FROM_PREV    = 2'd1;
  localparam logic [1:0] FROM_NEXT    = 2'd2;
  localparam logic [1:0] FROM_DEFAULT = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FLUSH,
    S_CUR
  } state_t;

  typedef enum logic [1:0] {
    KIND_DEFAULT,
    KIND_SAMPLE,
    KIND_LAST,
    KIND_QUEUE
  } kind_t;

  typedef enum logic [2:0] {
    SEL_END,
    SEL_NEAR,
    SEL_PASS,
    SEL_CUR_DEF,
    SEL_CUR_END
  } out_sel_t;

  typedef struct packed {
    logic     capture;
    logic     enqueue;
    logic     pop;
    logic     ovf_write;
    logic     load_out;
    out_sel_t out_sel;
    logic     out_ovf;
    logic     out_last;
    logic     finish_sample;
    logic     clear_session;
  } cmd_t;

  typedef struct packed {
    logic is_sample;
    logic fill_mode;
    logic in_last;
    logic q_empty;
    logic q_full;
    logic q_one;
    logic out_free;
    logic cap_last;
  } sts_t;

endpackage

>>> rtl/core/nspf_in_if.sv
// ----------------------------------------------------------------------------
// nspf_in_if
// Record input channel: valid/ready handshake with the record payload.
// ----------------------------------------------------------------------------
interface nspf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  record_type;
  logic [31:0] rec_time;
  logic [31:0] led_coords;
  logic [31:0] room_pose;
  logic [31:0] arena_pose;
  logic        last_record;

  modport source (
    output valid, record_type, rec_time, led_coords, room_pose, arena_pose,
           last_record,
    input  ready
  );

  modport sink (
    input  valid, record_type, rec_time, led_coords, room_pose, arena_pose,
           last_record,
    output ready
  );
endinterface

>>> rtl/core/nspf_out_if.sv
// ----------------------------------------------------------------------------
// nspf_out_if
// Result channel: valid/ready handshake with the filled record payload.
// ----------------------------------------------------------------------------
interface nspf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_type;
  logic [31:0] out_time;
  logic [31:0] out_led_coords;
  logic [31:0] out_room_pose;
  logic [31:0] out_arena_pose;
  logic [1:0]  filled_from;
  logic        queue_overflow;
  logic        last_of_run;

  modport source (
    output valid, out_type, out_time, out_led_coords, out_room_pose,
           out_arena_pose, filled_from, queue_overflow, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, out_type, out_time, out_led_coords, out_room_pose,
           out_arena_pose, filled_from, queue_overflow, last_of_run,
    output ready
  );
endinterface

>>> rtl/core/nspf_cfg.sv
// ----------------------------------------------------------------------------
// nspf_cfg
// APB-style configuration registers: position type code and default fill mode.
// ----------------------------------------------------------------------------
module nspf_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nspf_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [7:0]                   pos_code,
  output logic                         fill_mode
);
  import nspf_pkg::*;

  logic [7:0] pos_code_r, pos_code_nxt;
  logic       fill_mode_r, fill_mode_nxt;
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    pos_code_nxt  = pos_code_r;
    fill_mode_nxt = fill_mode_r;
    if (wr_en) begin
      case (reg_idx)
        REG_POS_CODE:  pos_code_nxt  = pwdata[7:0];
        REG_FILL_MODE: fill_mode_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POS_CODE:  prdata = {24'd0, pos_code_r};
      REG_FILL_MODE: prdata = {31'd0, fill_mode_r};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_code_r  <= 8'd0;
      fill_mode_r <= 1'b0;
    end else begin
      pos_code_r  <= pos_code_nxt;
      fill_mode_r <= fill_mode_nxt;
    end
  end

  assign pos_code  = pos_code_r;
  assign fill_mode = fill_mode_r;

endmodule

>>> rtl/core/nspf_ctrl.sv
// ----------------------------------------------------------------------------
// nspf_ctrl
// Sequencer: classifies each record, drains the pending queue, emits results.
// ----------------------------------------------------------------------------
module nspf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  nspf_pkg::sts_t  sts,
  output nspf_pkg::cmd_t  cmd
);
  import nspf_pkg::*;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;
  kind_t  kind_in;

  always_comb begin
    if (sts.fill_mode) begin
      kind_in = KIND_DEFAULT;
    end else if (sts.is_sample) begin
      kind_in = KIND_SAMPLE;
    end else if (sts.in_last) begin
      kind_in = KIND_LAST;
    end else begin
      kind_in = KIND_QUEUE;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = kind_in;
          if (kind_in == KIND_QUEUE) begin
            // full queue: release the oldest first, then store in its slot
            if (sts.q_full) state_nxt = S_FLUSH;
          end else if (sts.q_empty) begin
            state_nxt = S_CUR;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          if (kind_r == KIND_QUEUE) begin
            state_nxt = S_IDLE;
          end else if (sts.q_one) begin
            state_nxt = S_CUR;
          end
        end
      end
      S_CUR: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (kind_in == KIND_QUEUE && !sts.q_full) cmd.enqueue = 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = (kind_r == KIND_SAMPLE) ? SEL_NEAR : SEL_END;
          if (kind_r == KIND_QUEUE) begin
            cmd.out_ovf   = 1'b1;
            cmd.out_last  = 1'b1;
            cmd.ovf_write = 1'b1;
          end else begin
            cmd.pop = 1'b1;
          end
        end
      end
      S_CUR: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_last = 1'b1;
          case (kind_r)
            KIND_DEFAULT: cmd.out_sel = SEL_CUR_DEF;
            KIND_SAMPLE:  cmd.out_sel = SEL_PASS;
            default:      cmd.out_sel = SEL_CUR_END;
          endcase
          cmd.finish_sample = (kind_r == KIND_SAMPLE);
          cmd.clear_session = sts.cap_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= KIND_QUEUE;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

>>> rtl/core/nspf_dp.sv
// ----------------------------------------------------------------------------
// nspf_dp
// Datapath: captured record, pending ring memory, last sample and result register.
// ----------------------------------------------------------------------------
`include "nearest_sample_position_fill_assert.svh"

module nspf_dp #(
  parameter int PENDING_DEPTH = nspf_pkg::PENDING_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  nspf_pkg::cmd_t  cmd,
  output nspf_pkg::sts_t  sts,
  input  logic [7:0]      pos_code,
  input  logic            fill_mode,
  input  logic [7:0]      in_type,
  input  logic [31:0]     in_time,
  input  logic [31:0]     in_led,
  input  logic [31:0]     in_room,
  input  logic [31:0]     in_arena,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_type,
  output logic [31:0]     out_time,
  output logic [31:0]     out_led,
  output logic [31:0]     out_room,
  output logic [31:0]     out_arena,
  output logic [1:0]      out_from,
  output logic            out_ovf,
  output logic            out_last
);
  import nspf_pkg::*;

  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int EW = 40;

  // captured record
  logic [7:0]  cap_type_r;
  logic [31:0] cap_time_r, cap_led_r, cap_room_r, cap_arena_r;
  logic        cap_last_r;

  // pending ring
  logic [EW-1:0] mem [0:PENDING_DEPTH-1];
  logic [EW-1:0] rd_data_r;
  logic [AW-1:0] head_r, head_nxt, head_inc, tail;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW:0]   tail_sum;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  // last sample
  logic        have_sample_r, have_sample_nxt;
  logic [31:0] samp_led_r, samp_room_r, samp_arena_r, samp_time_r;
  logic [31:0] samp_led_nxt, samp_room_nxt, samp_arena_nxt, samp_time_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_type_r, res_type;
  logic [31:0] out_time_r, out_led_r, out_room_r, out_arena_r;
  logic [31:0] res_time, res_led, res_room, res_arena;
  logic [1:0]  out_from_r, res_from;
  logic        out_ovf_r, out_last_r;

  logic [7:0]  pend_type;
  logic [31:0] pend_time;
  logic [31:0] end_led, end_room, end_arena;
  logic [1:0]  end_from;
  logic [31:0] dist_prev, dist_next;
  logic        prev_nearer;

  // ring pointers
  assign head_inc = (head_r == AW'(PENDING_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum = {1'b0, head_r} + (AW+1)'(count_r);
  assign tail     = (tail_sum >= (AW+1)'(PENDING_DEPTH)) ?
                    AW'(tail_sum - (AW+1)'(PENDING_DEPTH)) : tail_sum[AW-1:0];

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.clear_session) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (cmd.pop || cmd.ovf_write) head_nxt = head_inc;
      if (cmd.enqueue)   count_nxt = count_r + 1'b1;
      else if (cmd.pop)  count_nxt = count_r - 1'b1;
    end
  end

  // overflow write reuses the slot of the record just released
  assign mem_we    = cmd.enqueue || cmd.ovf_write;
  assign mem_waddr = cmd.ovf_write ? head_r : tail;
  assign mem_wdata = cmd.ovf_write ? {cap_type_r, cap_time_r} : {in_type, in_time};

  // read port tracks the head every cycle, so the oldest entry is always staged
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[head_nxt];
  end

  assign pend_type = rd_data_r[EW-1:32];
  assign pend_time = rd_data_r[31:0];

  // fill from the previous sample, or midpoints if there is none
  always_comb begin
    if (have_sample_r) begin
      end_led   = samp_led_r;
      end_room  = samp_room_r;
      end_arena = samp_arena_r;
      end_from  = FROM_PREV;
    end else begin
      end_led   = MID_LED;
      end_room  = MID_POSE;
      end_arena = MID_POSE;
      end_from  = FROM_DEFAULT;
    end
  end

  assign dist_prev   = pend_time - samp_time_r;
  assign dist_next   = cap_time_r - pend_time;
  assign prev_nearer = have_sample_r && (dist_prev < dist_next);

  always_comb begin
    res_type  = pend_type;
    res_time  = pend_time;
    res_led   = end_led;
    res_room  = end_room;
    res_arena = end_arena;
    res_from  = end_from;
    case (cmd.out_sel)
      SEL_END: ;
      SEL_NEAR: begin
        if (!prev_nearer) begin
          res_led   = cap_led_r;
          res_room  = cap_room_r;
          res_arena = cap_arena_r;
          res_from  = FROM_NEXT;
        end
      end
      SEL_PASS: begin
        res_type  = cap_type_r;
        res_time  = cap_time_r;
        res_led   = cap_led_r;
        res_room  = cap_room_r;
        res_arena = cap_arena_r;
        res_from  = FROM_PASS;
      end
      SEL_CUR_DEF: begin
        res_type  = cap_type_r;
        res_time  = cap_time_r;
        res_led   = MID_LED;
        res_room  = {MID_POSE[31:16], cap_room_r[15:0]};
        res_arena = {MID_POSE[31:16], cap_arena_r[15:0]};
        res_from  = FROM_DEFAULT;
      end
      SEL_CUR_END: begin
        res_type = cap_type_r;
        res_time = cap_time_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    have_sample_nxt = have_sample_r;
    samp_led_nxt    = samp_led_r;
    samp_room_nxt   = samp_room_r;
    samp_arena_nxt  = samp_arena_r;
    samp_time_nxt   = samp_time_r;
    if (cmd.clear_session) begin
      have_sample_nxt = 1'b0;
      samp_led_nxt    = '0;
      samp_room_nxt   = '0;
      samp_arena_nxt  = '0;
      samp_time_nxt   = '0;
    end else if (cmd.finish_sample) begin
      have_sample_nxt = 1'b1;
      samp_led_nxt    = cap_led_r;
      samp_room_nxt   = cap_room_r;
      samp_arena_nxt  = cap_arena_r;
      samp_time_nxt   = cap_time_r;
    end
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      count_r       <= '0;
      have_sample_r <= 1'b0;
      samp_led_r    <= '0;
      samp_room_r   <= '0;
      samp_arena_r  <= '0;
      samp_time_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      have_sample_r <= have_sample_nxt;
      samp_led_r    <= samp_led_nxt;
      samp_room_r   <= samp_room_nxt;
      samp_arena_r  <= samp_arena_nxt;
      samp_time_r   <= samp_time_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_type_r  <= in_type;
      cap_time_r  <= in_time;
      cap_led_r   <= in_led;
      cap_room_r  <= in_room;
      cap_arena_r <= in_arena;
      cap_last_r  <= in_last;
    end
    if (cmd.load_out) begin
      out_type_r  <= res_type;
      out_time_r  <= res_time;
      out_led_r   <= res_led;
      out_room_r  <= res_room;
      out_arena_r <= res_arena;
      out_from_r  <= res_from;
      out_ovf_r   <= cmd.out_ovf;
      out_last_r  <= cmd.out_last;
    end
  end

  assign sts.is_sample = (in_type == pos_code);
  assign sts.fill_mode = fill_mode;
  assign sts.in_last   = in_last;
  assign sts.q_empty   = (count_r == '0);
  assign sts.q_full    = (count_r == CW'(PENDING_DEPTH));
  assign sts.q_one     = (count_r == CW'(1));
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.cap_last  = cap_last_r;

  assign out_valid = out_valid_r;
  assign out_type  = out_type_r;
  assign out_time  = out_time_r;
  assign out_led   = out_led_r;
  assign out_room  = out_room_r;
  assign out_arena = out_arena_r;
  assign out_from  = out_from_r;
  assign out_ovf   = out_ovf_r;
  assign out_last  = out_last_r;

  `NSPF_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(PENDING_DEPTH), "pending count above depth")
  `NSPF_ASSERT_IMPLIES(a_load_free, clk, rst_n, cmd.load_out, !out_valid_r || out_ready, "result overwritten before taken")
  `NSPF_ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, cmd.pop || cmd.ovf_write, count_r != '0, "pop from empty queue")
  `NSPF_ASSERT_NEXT(a_clear_session, clk, rst_n, cmd.clear_session, count_r == '0 && !have_sample_r, "session not cleared")

endmodule

>>> rtl/core/nearest_sample_position_fill.sv
// ----------------------------------------------------------------------------
// nearest_sample_position_fill
// Fills non-sample records with the coordinates of the nearest position sample.
// ----------------------------------------------------------------------------
// Records enter on in_if and results leave on out_if, both valid/ready; a
// transaction completes when valid and ready are high at a rising edge.
// Outside default fill mode, position samples pass straight through; other
// records wait in a pending ring until the next sample, then leave oldest
// first with the nearer sample's coordinates. A session-end record, or any
// record in default fill mode, releases them with the previous sample's
// coordinates (midpoints if none) before it leaves; a queued record meeting
// a full ring takes the oldest one's slot, and the oldest leaves flagged.
// psel/penable/pwrite/paddr/pwdata program the position type code (addr 0)
// and default fill mode (addr 4). The ring has a single write port and a
// registered read port that follows the head pointer, and one output
// register carries each result, so the release rate is one per cycle while
// out_if is ready. Reset empties the ring, forgets the last sample, clears
// the output valid and both config registers. On an out_if stall the block
// holds its result and waits; a new record is accepted while it is held.
// ----------------------------------------------------------------------------
module nearest_sample_position_fill #(
  parameter int PENDING_DEPTH = nspf_pkg::PENDING_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  nspf_in_if.sink                      in_if,
  nspf_out_if.source                   out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nspf_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import nspf_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [7:0] pos_code;
  logic       fill_mode;

  nspf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pos_code  (pos_code),
    .fill_mode (fill_mode)
  );

  nspf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nspf_dp #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .pos_code  (pos_code),
    .fill_mode (fill_mode),
    .in_type   (in_if.record_type),
    .in_time   (in_if.rec_time),
    .in_led    (in_if.led_coords),
    .in_room   (in_if.room_pose),
    .in_arena  (in_if.arena_pose),
    .in_last   (in_if.last_record),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_type  (out_if.out_type),
    .out_time  (out_if.out_time),
    .out_led   (out_if.out_led_coords),
    .out_room  (out_if.out_room_pose),
    .out_arena (out_if.out_arena_pose),
    .out_from  (out_if.filled_from),
    .out_ovf   (out_if.queue_overflow),
    .out_last  (out_if.last_of_run)
  );

endmodule
